FILE: design/ebr_pkg.sv
// Shared types and constants of the event bus router.
package ebr_pkg;

	localparam int KIND_ENTRIES    = 32;
	localparam int PENDING_ENTRIES = 16;
	localparam int CLIENT_SLOTS    = 64;

	localparam int KIND_IDX_W = (KIND_ENTRIES > 1) ? $clog2(KIND_ENTRIES) : 1;
	localparam int PEND_IDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
	localparam int SLOT_W     = 6;
	localparam int MASK_W     = 64;
	localparam int SRV_W      = 7;
	localparam int CNT_W      = 7;
	localparam int KIND_W     = 32;
	localparam int CORR_W     = 64;
	localparam int SEQ_W      = 64;

	localparam logic [SRV_W-1:0] NO_SERVER = 7'd64;
	localparam logic [CNT_W-1:0] SLOT_MAX  = CNT_W'(CLIENT_SLOTS);

	localparam logic [1:0] MODE_ROUTE   = 2'd0;
	localparam logic [1:0] MODE_SUB     = 2'd1;
	localparam logic [1:0] MODE_SERVE   = 2'd2;
	localparam logic [1:0] MODE_FORGET  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD       = 2'd1;
	localparam logic [1:0] ST_ARENA     = 2'd2;
	localparam logic [1:0] ST_NO_ROUTE  = 2'd3;

	localparam logic REG_SLOT_COUNT  = 1'b0;
	localparam logic REG_ACTIVE_MASK = 1'b1;

	typedef enum logic [3:0] {
		OP_SUB,
		OP_SERVE,
		OP_FORGET,
		OP_ARENA,
		OP_NOTIFY,
		OP_REQ,
		OP_REPLY,
		OP_CANCEL,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_FAN
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [SLOT_W-1:0]  src;
		logic [KIND_W-1:0]  kind;
		logic [CORR_W-1:0]  corr;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

FILE: design/ebr_front.sv
// Front end: accepts input transfers, classifies them and queues them for the back end.
module ebr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [ebr_pkg::SLOT_W-1:0]  origin_slot,
	input  logic [ebr_pkg::KIND_W-1:0]  kind_code,
	input  logic [ebr_pkg::CORR_W-1:0]  corr_tag,
	input  logic [4:0]                  frame_flags,
	input  logic                        pop,
	output ebr_pkg::head_t              head
);

	ebr_pkg::item_t q_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	ebr_pkg::op_t   op;
	logic           push;

	always_comb begin
		op = ebr_pkg::OP_NONE;
		case (mode)
			ebr_pkg::MODE_SUB:    op = ebr_pkg::OP_SUB;
			ebr_pkg::MODE_SERVE:  op = ebr_pkg::OP_SERVE;
			ebr_pkg::MODE_FORGET: op = ebr_pkg::OP_FORGET;
			default: begin
				// first set flag wins
				if (frame_flags[0])      op = ebr_pkg::OP_ARENA;
				else if (frame_flags[1]) op = ebr_pkg::OP_NOTIFY;
				else if (frame_flags[2]) op = ebr_pkg::OP_REQ;
				else if (frame_flags[3]) op = ebr_pkg::OP_REPLY;
				else if (frame_flags[4]) op = ebr_pkg::OP_CANCEL;
				else                     op = ebr_pkg::OP_NONE;
			end
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign head     = '{valid: (cnt_q != 2'd0), item: q_q[rd_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= '{op: op, src: origin_slot, kind: kind_code, corr: corr_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: design/ebr_back.sv
// Back end: kind and pending tables, sequence counter, execution and result register.
module ebr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ebr_pkg::head_t              head,
	output logic                        pop,
	input  logic [ebr_pkg::CNT_W-1:0]   slot_count,
	input  logic [ebr_pkg::MASK_W-1:0]  active_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        delivery_valid,
	output logic [ebr_pkg::SLOT_W-1:0]  dest_slot,
	output logic [ebr_pkg::SEQ_W-1:0]   frame_seq,
	output logic [ebr_pkg::SEQ_W-1:0]   event_seq,
	output logic                        absent_reply,
	output logic [1:0]                  status,
	output logic                        last
);

	localparam int K  = ebr_pkg::KIND_ENTRIES;
	localparam int P  = ebr_pkg::PENDING_ENTRIES;
	localparam int KW = ebr_pkg::KIND_IDX_W;
	localparam int PW = ebr_pkg::PEND_IDX_W;
	localparam int SW = ebr_pkg::SLOT_W;
	localparam int MW = ebr_pkg::MASK_W;
	localparam int QW = ebr_pkg::SEQ_W;

	ebr_pkg::back_state_t state_q, state_d;

	logic                       kind_valid_q [K];
	logic [ebr_pkg::KIND_W-1:0] kind_id_q    [K];
	logic [MW-1:0]              obs_q        [K];
	logic [ebr_pkg::SRV_W-1:0]  srv_q        [K];
	logic                       pend_valid_q [P];
	logic [ebr_pkg::CORR_W-1:0] pend_corr_q  [P];
	logic [SW-1:0]              pend_req_q   [P];
	logic [SW-1:0]              pend_srv_q   [P];
	logic [QW-1:0]              seq_q;

	ebr_pkg::item_t item_q;
	logic           k_hit_q, p_hit_q;
	logic [KW-1:0]  k_idx_q;
	logic [PW-1:0]  p_idx_q;
	logic [MW-1:0]  rem_q;
	logic [QW-1:0]  eseq_q;

	logic           ov_q, dv_q, abs_q, last_q;
	logic [SW-1:0]  dest_q;
	logic [QW-1:0]  fseq_q, eseq_out_q;
	logic [1:0]     st_q;

	// lookup against the queue head
	logic          k_hit, p_hit, kfree_any, pfree_any;
	logic [KW-1:0] k_idx, kfree_idx;
	logic [PW-1:0] p_idx, pfree_idx;

	always_comb begin
		k_hit = 1'b0;
		k_idx = '0;
		kfree_any = 1'b0;
		kfree_idx = '0;
		for (int i = K - 1; i >= 0; i--) begin
			if (kind_valid_q[i] && kind_id_q[i] == head.item.kind) begin
				k_hit = 1'b1;
				k_idx = KW'(i);
			end
			if (!kind_valid_q[i]) begin
				kfree_any = 1'b1;
				kfree_idx = KW'(i);
			end
		end
	end

	always_comb begin
		p_hit = 1'b0;
		p_idx = '0;
		pfree_any = 1'b0;
		pfree_idx = '0;
		for (int i = P - 1; i >= 0; i--) begin
			if (pend_valid_q[i] && pend_corr_q[i] == head.item.corr) begin
				p_hit = 1'b1;
				p_idx = PW'(i);
			end
			if (!pend_valid_q[i]) begin
				pfree_any = 1'b1;
				pfree_idx = PW'(i);
			end
		end
	end

	// execution helpers
	logic [ebr_pkg::CNT_W-1:0] lim;
	logic [MW-1:0]             lim_mask, nm, fm, fm_rest;
	logic [SW-1:0]             first;
	logic [MW-1:0]             cur_obs, base_obs, src_bit;
	logic [ebr_pkg::SRV_W-1:0] cur_srv, base_srv;
	logic [KW-1:0]             sel_k;
	logic                      reg_ok, serve_ok, srv_ok, out_free;
	logic [QW-1:0]             eseq1, eseq2;
	logic [SW-1:0]             p_req, p_srv;

	assign lim      = (slot_count > ebr_pkg::SLOT_MAX) ? ebr_pkg::SLOT_MAX : slot_count;
	assign out_free = !ov_q || out_ready;
	assign cur_obs  = obs_q[k_idx_q];
	assign cur_srv  = srv_q[k_idx_q];
	assign sel_k    = k_hit_q ? k_idx_q : kfree_idx;
	assign base_obs = k_hit_q ? cur_obs : '0;
	assign base_srv = k_hit_q ? cur_srv : ebr_pkg::NO_SERVER;
	assign src_bit  = MW'(1) << item_q.src;
	assign reg_ok   = ({1'b0, item_q.src} < lim) && active_mask[item_q.src]
	                  && (k_hit_q || kfree_any);
	assign serve_ok = (base_srv == ebr_pkg::NO_SERVER) || (base_srv == {1'b0, item_q.src});
	assign srv_ok   = k_hit_q && !cur_srv[6] && active_mask[cur_srv[SW-1:0]];
	assign eseq1    = seq_q + QW'(1);
	assign eseq2    = seq_q + QW'(2);
	assign p_req    = pend_req_q[p_idx_q];
	assign p_srv    = pend_srv_q[p_idx_q];

	always_comb begin
		for (int s = 0; s < MW; s++) begin
			lim_mask[s] = (ebr_pkg::CNT_W'(s) < lim);
		end
	end

	assign nm      = cur_obs & active_mask & lim_mask;
	assign fm      = (state_q == ebr_pkg::B_FAN) ? rem_q : nm;
	assign fm_rest = fm & (fm - MW'(1));

	always_comb begin
		first = '0;
		for (int s = MW - 1; s >= 0; s--) begin
			if (fm[s]) first = SW'(s);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ebr_pkg::B_IDLE: begin
				if (head.valid) state_d = ebr_pkg::B_EXEC;
			end
			ebr_pkg::B_EXEC: begin
				if (out_free) begin
					if (item_q.op == ebr_pkg::OP_NOTIFY && k_hit_q && fm_rest != '0)
						state_d = ebr_pkg::B_FAN;
					else
						state_d = ebr_pkg::B_IDLE;
				end
			end
			ebr_pkg::B_FAN: begin
				if (out_free && fm_rest == '0) state_d = ebr_pkg::B_IDLE;
			end
			default: state_d = ebr_pkg::B_IDLE;
		endcase
	end

	// actions
	logic           emit, e_dv, e_abs, e_last;
	logic [SW-1:0]  e_dest;
	logic [QW-1:0]  e_fseq, e_eseq, seq_d;
	logic [1:0]     e_st;
	logic           do_kind, do_forget, do_add, do_free;
	logic [MW-1:0]  new_obs;
	logic [ebr_pkg::SRV_W-1:0] new_srv;

	always_comb begin
		emit      = 1'b0;
		e_dv      = 1'b0;
		e_abs     = 1'b0;
		e_last    = 1'b1;
		e_dest    = '0;
		e_fseq    = '0;
		e_eseq    = '0;
		e_st      = ebr_pkg::ST_OK;
		seq_d     = seq_q;
		do_kind   = 1'b0;
		do_forget = 1'b0;
		do_add    = 1'b0;
		do_free   = 1'b0;
		new_obs   = base_obs;
		new_srv   = base_srv;
		pop       = (state_q == ebr_pkg::B_IDLE) && head.valid;
		if (state_q == ebr_pkg::B_FAN && out_free) begin
			emit   = 1'b1;
			e_dv   = 1'b1;
			e_dest = first;
			e_fseq = eseq_q;
			e_eseq = eseq_q;
			e_last = (fm_rest == '0);
		end else if (state_q == ebr_pkg::B_EXEC && out_free) begin
			emit = 1'b1;
			if (item_q.op != ebr_pkg::OP_SUB && item_q.op != ebr_pkg::OP_SERVE
			    && item_q.op != ebr_pkg::OP_FORGET) begin
				seq_d  = eseq1;
				e_eseq = eseq1;
			end
			case (item_q.op)
				ebr_pkg::OP_SUB: begin
					e_st = ebr_pkg::ST_BAD;
					if (reg_ok) begin
						do_kind = 1'b1;
						new_obs = base_obs | src_bit;
						e_st    = ebr_pkg::ST_OK;
					end
				end
				ebr_pkg::OP_SERVE: begin
					e_st = ebr_pkg::ST_BAD;
					if (reg_ok) begin
						do_kind = 1'b1;
						if (serve_ok) begin
							new_srv = {1'b0, item_q.src};
							e_st    = ebr_pkg::ST_OK;
						end
					end
				end
				ebr_pkg::OP_FORGET: do_forget = 1'b1;
				ebr_pkg::OP_ARENA:  e_st = ebr_pkg::ST_ARENA;
				ebr_pkg::OP_NOTIFY: begin
					if (!k_hit_q || nm == '0) begin
						e_st = ebr_pkg::ST_NO_ROUTE;
					end else begin
						e_dv   = 1'b1;
						e_dest = first;
						e_fseq = eseq1;
						e_last = (fm_rest == '0);
					end
				end
				ebr_pkg::OP_REQ: begin
					e_dv = 1'b1;
					if (srv_ok && pfree_any) begin
						do_add = 1'b1;
						e_dest = cur_srv[SW-1:0];
						e_fseq = eseq1;
					end else begin
						// capability-absent reply back to the requester
						seq_d  = eseq2;
						e_dest = item_q.src;
						e_fseq = eseq2;
						e_abs  = 1'b1;
						e_st   = srv_ok ? ebr_pkg::ST_BAD : ebr_pkg::ST_OK;
					end
				end
				ebr_pkg::OP_REPLY: begin
					e_st = ebr_pkg::ST_NO_ROUTE;
					if (p_hit_q && p_srv == item_q.src) begin
						do_free = 1'b1;
						if (active_mask[p_req]) begin
							e_dv   = 1'b1;
							e_dest = p_req;
							e_fseq = eseq1;
							e_st   = ebr_pkg::ST_OK;
						end
					end
				end
				ebr_pkg::OP_CANCEL: begin
					e_st = ebr_pkg::ST_NO_ROUTE;
					if (p_hit_q && p_req == item_q.src && active_mask[p_srv]) begin
						e_dv   = 1'b1;
						e_dest = p_srv;
						e_fseq = eseq1;
						e_st   = ebr_pkg::ST_OK;
					end
				end
				default: e_st = ebr_pkg::ST_NO_ROUTE;
			endcase
		end
	end

	// tables and payload
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q  <= head.item;
			k_idx_q <= k_idx;
			p_idx_q <= p_idx;
		end
		if (do_kind) begin
			kind_id_q[sel_k] <= item_q.kind;
			obs_q[sel_k]     <= new_obs;
			srv_q[sel_k]     <= new_srv;
		end
		if (do_forget) begin
			for (int i = 0; i < K; i++) begin
				obs_q[i] <= obs_q[i] & ~src_bit;
				if (srv_q[i] == {1'b0, item_q.src}) srv_q[i] <= ebr_pkg::NO_SERVER;
			end
		end
		if (do_add) begin
			pend_corr_q[pfree_idx] <= item_q.corr;
			pend_req_q[pfree_idx]  <= item_q.src;
			pend_srv_q[pfree_idx]  <= cur_srv[SW-1:0];
		end
		if (state_q == ebr_pkg::B_EXEC && out_free) begin
			rem_q  <= fm_rest;
			eseq_q <= eseq1;
		end else if (state_q == ebr_pkg::B_FAN && out_free) begin
			rem_q <= fm_rest;
		end
		if (emit) begin
			dv_q       <= e_dv;
			dest_q     <= e_dest;
			fseq_q     <= e_fseq;
			eseq_out_q <= e_eseq;
			abs_q      <= e_abs;
			st_q       <= e_st;
			last_q     <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ebr_pkg::B_IDLE;
			seq_q   <= '0;
			k_hit_q <= 1'b0;
			p_hit_q <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < K; i++) kind_valid_q[i] <= 1'b0;
			for (int i = 0; i < P; i++) pend_valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			seq_q   <= seq_d;
			if (pop) begin
				k_hit_q <= k_hit;
				p_hit_q <= p_hit;
			end
			if (emit)           ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (do_kind) kind_valid_q[sel_k] <= 1'b1;
			if (do_add)  pend_valid_q[pfree_idx] <= 1'b1;
			if (do_free) pend_valid_q[p_idx_q] <= 1'b0;
			if (do_forget) begin
				for (int i = 0; i < P; i++) begin
					if (pend_req_q[i] == item_q.src || pend_srv_q[i] == item_q.src)
						pend_valid_q[i] <= 1'b0;
				end
			end
		end
	end

	assign out_valid      = ov_q;
	assign delivery_valid = dv_q;
	assign dest_slot      = dest_q;
	assign frame_seq      = fseq_q;
	assign event_seq      = eseq_out_q;
	assign absent_reply   = abs_q;
	assign status         = st_q;
	assign last           = last_q;

	a_fan_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ebr_pkg::B_FAN |-> rem_q != '0)
		else $error("fan-out state with empty remainder");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ebr_pkg::B_EXEC && k_hit_q) |-> kind_valid_q[k_idx_q])
		else $error("kind hit on an invalid entry");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (seq_q - $past(seq_q)) <= QW'(2))
		else $error("sequence counter jumped");

endmodule

FILE: design/event_bus_router.sv
// Event bus router top level: configuration registers, front end and back end.
// Each input transfer is queued by the front end (two entries) and executed by the back end, which
// first looks the kind and correlation id up in the tables, then acts and loads the result register.
// A notification makes one delivery per cycle while the output is not stalled, in ascending slot
// order. The result register decouples the output, so a stalled result holds only the back end
// while the front end keeps accepting until its two entries are full. Registers:
// slot_count at byte 0, active_slot_mask at byte 8, 64-bit data; write them only while the block is idle.
module event_bus_router (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [ebr_pkg::SLOT_W-1:0]  origin_slot,
	input  logic [ebr_pkg::KIND_W-1:0]  kind_code,
	input  logic [ebr_pkg::CORR_W-1:0]  corr_tag,
	input  logic [4:0]                  frame_flags,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        delivery_valid,
	output logic [ebr_pkg::SLOT_W-1:0]  dest_slot,
	output logic [ebr_pkg::SEQ_W-1:0]   frame_seq,
	output logic [ebr_pkg::SEQ_W-1:0]   event_seq,
	output logic                        absent_reply,
	output logic [1:0]                  status,
	output logic                        last
);

	logic [ebr_pkg::CNT_W-1:0]  slot_count_q;
	logic [ebr_pkg::MASK_W-1:0] active_mask_q;
	ebr_pkg::head_t             head;
	logic                       pop;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[3] == ebr_pkg::REG_ACTIVE_MASK) ? active_mask_q
	                : {57'd0, slot_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= 7'd64;
			active_mask_q <= '0;
		end else if (wr) begin
			if (paddr[3] == ebr_pkg::REG_SLOT_COUNT) slot_count_q <= pwdata[6:0];
			else                                     active_mask_q <= pwdata;
		end
	end

	ebr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.origin_slot (origin_slot),
		.kind_code   (kind_code),
		.corr_tag    (corr_tag),
		.frame_flags (frame_flags),
		.pop         (pop),
		.head        (head)
	);

	ebr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.slot_count     (slot_count_q),
		.active_mask    (active_mask_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.delivery_valid (delivery_valid),
		.dest_slot      (dest_slot),
		.frame_seq      (frame_seq),
		.event_seq      (event_seq),
		.absent_reply   (absent_reply),
		.status         (status),
		.last           (last)
	);

endmodule
